// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks sampled on clk, switched off while rst is high
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/jslu_pkg.sv =====
// ----------------------------------------------------------------------------
// jslu_pkg
// types, character codes and decode helpers for the string literal unescaper
// ----------------------------------------------------------------------------
package jslu_pkg;

  // kind of result carried with each output item
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  // character codes
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_U      = 8'h75;

  // control bytes produced by escapes
  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_HT = 8'h09;
  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_BS = 8'h08;
  localparam logic [7:0] BYTE_FF = 8'h0C;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_dig_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] val;
  } esc_map_t;

  // hex digit decode, either case
  function automatic hex_dig_t hex_digit(input logic [7:0] c);
    hex_dig_t r;
    r = '{ok: 1'b0, val: 4'd0};
    if (c inside {[8'h30:8'h39]}) begin
      r.ok  = 1'b1;
      r.val = 4'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      r.ok  = 1'b1;
      r.val = 4'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      r.ok  = 1'b1;
      r.val = 4'(c - 8'h37);
    end
    return r;
  endfunction

  // single-letter escape map
  function automatic esc_map_t escape_map(input logic [7:0] c);
    esc_map_t r;
    r = '{ok: 1'b1, val: c};
    case (c)
      CH_QUOTE, CH_BSLASH, CH_SLASH: r.val = c;
      CH_N:    r.val = BYTE_LF;
      CH_T:    r.val = BYTE_HT;
      CH_R:    r.val = BYTE_CR;
      CH_B:    r.val = BYTE_BS;
      CH_F:    r.val = BYTE_FF;
      default: r = '{ok: 1'b0, val: 8'd0};
    endcase
    return r;
  endfunction

endpackage

// ===== sv/json_string_literal_unescape.sv =====
// an accepted item passes through the input register, then the result register
// throughput: one item per cycle while result_stall is low; the scan state updates as an item
// moves to the result register, so consecutive bytes see each other's state without a bubble
// reset: synchronous active-high rst empties both registers, sets the scanner to
// wait for an opening quote and clears the hex accumulator
// ----------------------------------------------------------------------------
// json_string_literal_unescape
// decodes a double-quoted string literal one byte per item, with escapes
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module json_string_literal_unescape (
  input  logic                clk,
  input  logic                rst,
  input  logic                text_valid,
  output logic                text_stall,
  input  logic [7:0]          text_byte,
  input  logic                text_end,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [7:0]          decoded_byte,
  output jslu_pkg::kind_t     result_kind
);
  import jslu_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_BODY = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX1 = 3'd3,
    PH_HEX2 = 3'd4,
    PH_HEX3 = 3'd5,
    PH_HEX4 = 3'd6
  } phase_t;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_end;

  // scan state
  phase_t     phase, phase_next;
  logic [7:0] hex_acc, hex_acc_next;

  // decode outputs
  kind_t      kind_next;
  logic [7:0] byte_next;
  logic       advance;
  hex_dig_t   dig;
  esc_map_t   esc;

  // terms for the checks
  logic       lit_done;
  logic       hex_start;
  logic       out_not_byte;

  // move the held item into the result register when it is free or draining
  assign advance    = s1_valid && (!result_valid || !result_stall);
  assign text_stall = s1_valid && !advance;

  assign dig = hex_digit(s1_byte);
  assign esc = escape_map(s1_byte);

  // per-byte decode
  always_comb begin
    kind_next    = KIND_NONE;
    byte_next    = 8'd0;
    phase_next   = phase;
    hex_acc_next = hex_acc;
    case (phase)
      PH_IDLE: begin
        if (s1_byte == CH_QUOTE) phase_next = PH_BODY;
        else kind_next = KIND_ERROR;
      end
      PH_BODY: begin
        if (s1_byte == CH_QUOTE) begin
          kind_next  = KIND_CLOSE;
          phase_next = PH_IDLE;
        end else if (s1_byte == CH_BSLASH) begin
          phase_next = PH_ESC;
        end else begin
          kind_next = KIND_BYTE;
          byte_next = s1_byte;
        end
      end
      PH_ESC: begin
        if (esc.ok) begin
          kind_next  = KIND_BYTE;
          byte_next  = esc.val;
          phase_next = PH_BODY;
        end else if (s1_byte == CH_U) begin
          hex_acc_next = 8'd0;
          phase_next   = PH_HEX1;
        end else begin
          kind_next = KIND_ERROR;
        end
      end
      PH_HEX1, PH_HEX2, PH_HEX3: begin
        if (!dig.ok) begin
          kind_next = KIND_ERROR;
        end else begin
          hex_acc_next = {hex_acc[3:0], dig.val};
          phase_next   = phase_t'(phase + 3'd1);
        end
      end
      PH_HEX4: begin
        if (!dig.ok) begin
          kind_next = KIND_ERROR;
        end else begin
          hex_acc_next = {hex_acc[3:0], dig.val};
          kind_next    = KIND_BYTE;
          byte_next    = {hex_acc[3:0], dig.val};
          phase_next   = PH_BODY;
        end
      end
      default: kind_next = KIND_ERROR;
    endcase

    // text ended before the literal closed
    if (s1_end && kind_next != KIND_CLOSE && kind_next != KIND_ERROR) begin
      kind_next = KIND_ERROR;
    end
    if (kind_next == KIND_ERROR || kind_next == KIND_CLOSE) begin
      phase_next   = PH_IDLE;
      hex_acc_next = 8'd0;
    end
    if (kind_next != KIND_BYTE) byte_next = 8'd0;
  end

  // input register, scan state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      phase        <= PH_IDLE;
      hex_acc      <= 8'd0;
    end else begin
      if (!text_stall) begin
        s1_valid <= text_valid;
      end
      if (advance) begin
        result_valid <= 1'b1;
        phase        <= phase_next;
        hex_acc      <= hex_acc_next;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!text_stall && text_valid) begin
      s1_byte <= text_byte;
      s1_end  <= text_end;
    end
    if (advance) begin
      decoded_byte <= byte_next;
      result_kind  <= kind_next;
    end
  end

  // check terms
  assign lit_done     = advance && (kind_next == KIND_ERROR || kind_next == KIND_CLOSE);
  assign hex_start    = advance && phase == PH_ESC && s1_byte == CH_U && !s1_end;
  assign out_not_byte = result_valid && result_kind != KIND_BYTE;

  // checks
  `ASSERT_NXT(a_end_to_idle, lit_done, phase == PH_IDLE, "scanner not idle after close or error")
  `ASSERT_IMP(a_byte_zero, out_not_byte, decoded_byte == 8'd0, "stray decoded byte")
  `ASSERT_IMP(a_stall_full, text_stall, s1_valid && result_valid && result_stall, "needless stall")
  `ASSERT_NXT(a_hex_clear, hex_start, hex_acc == 8'd0 && phase == PH_HEX1, "dirty unicode start")

endmodule
